FILE: rtl/dnsqp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsqp_pkg: shared types and constants of the DNS question parser
// Word formats of both channels, the parse phases and the result kinds.
// ----------------------------------------------------------------------------
package dnsqp_pkg;

	// Longest name, in characters with the dots, that is passed on.
	localparam logic [7:0] NAME_LIMIT = 8'd254;

	// The only question count that is accepted.
	localparam logic [15:0] ONE_QUESTION = 16'd1;

	localparam logic [7:0] DOT_CHAR = 8'h2E;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_LENGTH   = 3'd1,
		PH_LABEL    = 3'd2,
		PH_TYPE_HI  = 3'd3,
		PH_TYPE_LO  = 3'd4,
		PH_CLASS_HI = 3'd5,
		PH_CLASS_LO = 3'd6,
		PH_DRAIN    = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		K_CHAR     = 3'd0,
		K_NAME_END = 3'd1,
		K_TYPE     = 3'd2,
		K_CLASS    = 3'd3,
		K_REJECT   = 3'd4,
		K_TOO_LONG = 3'd5
	} kind_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        msg_start;
		logic [15:0] question_count;
	} src_word_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] value;
		logic        final_res;
	} res_word_t;

endpackage

FILE: rtl/dns_question_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_question_parser_top: byte-serial DNS question section parser
// Reads one byte of a question section per word, gives out the name
// characters, the name length, the type and the class, and flags rejected
// question counts and names that are too long.
// ----------------------------------------------------------------------------
//
//   channel | handshake              | word                     | direction
//   --------+------------------------+--------------------------+----------
//   src     | src_valid / src_ready  | src_word  (src_word_t)   | into block
//   res     | res_valid / res_ready  | res_word  (res_word_t)   | out of block
//
// Each accepted word sits in the input register; the parse state and the
// result register are then updated from it, so a word can be taken every
// cycle while the result register is free or being emptied, and its result
// is offered from the result register after the word leaves the input
// register. A word that causes no result still passes through the same
// input register. Reset clears the parse state to idle and empties both
// registers. When the result register holds a word that is not taken, the
// input register stops only once it is full, so one more word is accepted.
//
module dns_question_parser_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_ready,
	input  dnsqp_pkg::src_word_t  src_word,
	output logic                  res_valid,
	input  logic                  res_ready,
	output dnsqp_pkg::res_word_t  res_word
);
	import dnsqp_pkg::*;

	// Input register.
	logic      valid_s1;
	src_word_t word_s1;

	// Parse state.
	phase_t     phase_q;
	logic [7:0] label_left_q;
	logic [7:0] name_length_q;
	logic       seen_label_q;
	logic [7:0] high_byte_q;

	// Result register.
	logic      res_valid_q;
	res_word_t res_word_q;

	// Next values from the parse logic.
	phase_t     phase_d;
	logic [7:0] label_left_d;
	logic [7:0] name_length_d;
	logic       seen_label_d;
	logic [7:0] high_byte_d;
	logic       emit_d;
	res_word_t  res_d;

	logic advance_s1;

	// The word in the input register is processed when the result register
	// is free or is being emptied in this cycle.
	assign advance_s1 = valid_s1 && (!res_valid_q || res_ready);
	assign src_ready  = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			word_s1 <= src_word;
		end
	end

	// Parse logic: one step of the question section state machine.
	always_comb begin
		phase_t     ph_eff;
		logic [7:0] len_eff;
		logic       seen_eff;
		logic       char_req;
		logic [7:0] char_val;

		phase_d       = phase_q;
		label_left_d  = label_left_q;
		name_length_d = name_length_q;
		seen_label_d  = seen_label_q;
		high_byte_d   = high_byte_q;
		emit_d        = 1'b0;
		res_d         = '{kind: K_CHAR, value: 16'd0, final_res: 1'b0};
		char_req      = 1'b0;
		char_val      = word_s1.data_byte;

		// A message start abandons whatever was in progress and reads its
		// byte as the first length byte of a fresh name.
		ph_eff   = word_s1.msg_start ? PH_LENGTH : phase_q;
		len_eff  = word_s1.msg_start ? 8'd0 : name_length_q;
		seen_eff = word_s1.msg_start ? 1'b0 : seen_label_q;

		if (word_s1.msg_start) begin
			label_left_d  = 8'd0;
			name_length_d = 8'd0;
			seen_label_d  = 1'b0;
			high_byte_d   = 8'd0;
		end

		if (word_s1.msg_start && word_s1.question_count != ONE_QUESTION) begin
			phase_d = PH_IDLE;
			emit_d  = 1'b1;
			res_d   = '{kind: K_REJECT, value: word_s1.question_count, final_res: 1'b1};
		end else begin
			case (ph_eff)
				PH_LENGTH: begin
					if (word_s1.data_byte == 8'd0) begin
						phase_d = PH_TYPE_HI;
						emit_d  = 1'b1;
						res_d   = '{kind: K_NAME_END, value: {8'd0, len_eff},
							final_res: 1'b0};
					end else begin
						label_left_d = word_s1.data_byte;
						phase_d      = PH_LABEL;
						if (seen_eff) begin
							char_req = 1'b1;
							char_val = DOT_CHAR;
						end else begin
							seen_label_d = 1'b1;
						end
					end
				end
				PH_LABEL: begin
					label_left_d = label_left_q - 8'd1;
					if (label_left_q == 8'd1) begin
						phase_d = PH_LENGTH;
					end
					char_req = 1'b1;
				end
				PH_TYPE_HI: begin
					high_byte_d = word_s1.data_byte;
					phase_d     = PH_TYPE_LO;
				end
				PH_TYPE_LO: begin
					phase_d = PH_CLASS_HI;
					emit_d  = 1'b1;
					res_d   = '{kind: K_TYPE, value: {high_byte_q, word_s1.data_byte},
						final_res: 1'b0};
				end
				PH_CLASS_HI: begin
					high_byte_d = word_s1.data_byte;
					phase_d     = PH_CLASS_LO;
				end
				PH_CLASS_LO: begin
					phase_d = PH_IDLE;
					emit_d  = 1'b1;
					res_d   = '{kind: K_CLASS, value: {high_byte_q, word_s1.data_byte},
						final_res: 1'b1};
				end
				default: begin
					// Idle or draining: the byte is dropped.
				end
			endcase
		end

		// A character or dot that would push the name past the limit is
		// replaced by the too-long flag, and the rest of the message drains.
		if (char_req) begin
			emit_d = 1'b1;
			if (len_eff >= NAME_LIMIT) begin
				phase_d = PH_DRAIN;
				res_d   = '{kind: K_TOO_LONG, value: 16'd0, final_res: 1'b1};
			end else begin
				name_length_d = len_eff + 8'd1;
				res_d         = '{kind: K_CHAR, value: {8'd0, char_val}, final_res: 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			label_left_q  <= 8'd0;
			name_length_q <= 8'd0;
			seen_label_q  <= 1'b0;
			high_byte_q   <= 8'd0;
		end else if (advance_s1) begin
			phase_q       <= phase_d;
			label_left_q  <= label_left_d;
			name_length_q <= name_length_d;
			seen_label_q  <= seen_label_d;
			high_byte_q   <= high_byte_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance_s1) begin
			res_valid_q <= emit_d;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && emit_d) begin
			res_word_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	// Only class, rejected count and too-long results close a question.
	a_final_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_word_q.final_res == (res_word_q.kind == K_CLASS
			|| res_word_q.kind == K_REJECT || res_word_q.kind == K_TOO_LONG)))
		else $error("final_res does not match result kind");

	// Inside a label there is always at least one byte left.
	a_label_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LABEL |-> label_left_q != 8'd0)
		else $error("label phase with no bytes left");

	// The name never grows past the limit.
	a_name_limit: assert property (@(posedge clk) disable iff (!arst_n)
		name_length_q <= NAME_LIMIT)
		else $error("name length beyond limit");

	// A rejected count leaves the parser idle.
	a_reject_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && word_s1.msg_start && word_s1.question_count != ONE_QUESTION)
		|=> (phase_q == PH_IDLE && res_valid_q && res_word_q.kind == K_REJECT))
		else $error("rejected count did not return to idle");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for dns_question_parser_top
// Sends question-section bytes one word at a time and follows every
// accepted word with a bit-accurate parser of its own. The expected
// results wait in a queue, and every result word that the block hands
// over is compared field by field with the oldest entry. Both channels
// idle at random, and one long receiver hold-off backs up the block.
// ----------------------------------------------------------------------------
module testbench;
	import dnsqp_pkg::*;

	// A stretch this long without a single handshake on either channel
	// means the block has hung.
	localparam int STALL_LIMIT  = 2000;
	// The receiver hold-off that fills the block and stalls its input.
	localparam int HOLD_CYCLES  = 300;
	// A word's result comes out of the result register once the word has left
	// the input register; this margin past the last expected result catches extras.
	localparam int SETTLE       = 10;
	localparam int RANDOM_ITEMS = 300;
	localparam int UNCUT        = 1 << 20;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_ready;
	src_word_t src_word = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	res_word_t res_word;

	dns_question_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_word  (src_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Parser state as the bench sees it. It is advanced once for every
	// word that the block accepts, in the same order.
	// ------------------------------------------------------------------
	phase_t     cur_phase = PH_IDLE;
	logic [7:0] bytes_in_label = '0;
	logic [7:0] chars_out = '0;
	logic       dot_due = 1'b0;
	logic [7:0] hi_byte = '0;

	res_word_t  pending_results[$];
	res_word_t  oldest;
	int         error_count = 0;
	int         parsed_items = 0;
	int         stalled_cycles = 0;

	// Set by the tests: no gaps on the sender and no stalls on the receiver.
	bit         steady_run = 1'b0;
	// A test raises hold_req; the receiver answers with one long hold-off
	// and shows that it is in it through holding.
	bit         hold_req = 1'b0;
	bit         holding = 1'b0;

	// Message building state: whether the next byte opens a message, and
	// how many bytes may still go out before the message is cut short.
	bit         opens_message;
	int         bytes_left;

	// One more character of the name. Once the name would grow past the
	// limit, the flag goes out instead and the rest of the message is
	// skipped until the next start.
	function automatic bit name_char_result(input logic [7:0] ch, output res_word_t r);
		r = '0;
		if (chars_out >= NAME_LIMIT) begin
			cur_phase = PH_DRAIN;
			r.kind = K_TOO_LONG;
			r.final_res = 1'b1;
		end else begin
			chars_out = chars_out + 8'd1;
			r.kind = K_CHAR;
			r.value = {8'h00, ch};
		end
		return 1'b1;
	endfunction

	// A length byte either ends the name or opens a label. Every label but
	// the first is preceded by a dot in the character stream. The top bits
	// of a length byte get no special meaning.
	function automatic bit length_byte_result(input logic [7:0] b, output res_word_t r);
		r = '0;
		if (b == 8'd0) begin
			cur_phase = PH_TYPE_HI;
			r.kind = K_NAME_END;
			r.value = {8'h00, chars_out};
			return 1'b1;
		end
		bytes_in_label = b;
		cur_phase = PH_LABEL;
		if (dot_due)
			return name_char_result(DOT_CHAR, r);
		dot_due = 1'b1;
		return 1'b0;
	endfunction

	// Advances the parser by one accepted word and tells whether a result
	// word is due for it.
	function automatic bit parse_byte(input src_word_t w, output res_word_t r);
		r = '0;
		if (w.msg_start) begin
			bytes_in_label = '0;
			chars_out = '0;
			dot_due = 1'b0;
			hi_byte = '0;
			if (w.question_count != ONE_QUESTION) begin
				cur_phase = PH_IDLE;
				r.kind = K_REJECT;
				r.value = w.question_count;
				r.final_res = 1'b1;
				return 1'b1;
			end
			return length_byte_result(w.data_byte, r);
		end
		case (cur_phase)
			PH_LENGTH: return length_byte_result(w.data_byte, r);
			PH_LABEL: begin
				bytes_in_label = bytes_in_label - 8'd1;
				if (bytes_in_label == 8'd0)
					cur_phase = PH_LENGTH;
				return name_char_result(w.data_byte, r);
			end
			PH_TYPE_HI: begin
				hi_byte = w.data_byte;
				cur_phase = PH_TYPE_LO;
				return 1'b0;
			end
			PH_TYPE_LO: begin
				cur_phase = PH_CLASS_HI;
				r.kind = K_TYPE;
				r.value = {hi_byte, w.data_byte};
				return 1'b1;
			end
			PH_CLASS_HI: begin
				hi_byte = w.data_byte;
				cur_phase = PH_CLASS_LO;
				return 1'b0;
			end
			PH_CLASS_LO: begin
				cur_phase = PH_IDLE;
				r.kind = K_CLASS;
				r.value = {hi_byte, w.data_byte};
				r.final_res = 1'b1;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (error_count < 50)
			$display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	// Offers one word and holds it until it is accepted. The handshake is
	// looked at on the falling edge, where every signal has settled, and
	// the word counts as taken at the rising edge that follows. A random
	// gap may follow, during which the payload carries junk.
	task automatic send_byte(input logic [7:0] data, input logic start,
			input logic [15:0] count);
		src_word_t w;
		src_word_t junk;
		res_word_t r;
		int        k;
		int        gap;
		w.data_byte = data;
		w.msg_start = start;
		w.question_count = count;
		src_valid <= 1'b1;
		src_word <= w;
		@(negedge clk);
		while (!src_ready)
			@(negedge clk);
		@(posedge clk);
		// Bytes that land on an idle or draining parser do nothing.
		if (start || (cur_phase != PH_IDLE && cur_phase != PH_DRAIN))
			parsed_items++;
		if (parse_byte(w, r))
			pending_results.push_back(r);
		k = $urandom_range(0, 99);
		if (steady_run || k < 55)
			gap = 0;
		else if (k < 88)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 40);
		if (gap > 0) begin
			junk.data_byte = 8'($urandom_range(0, 255));
			junk.msg_start = 1'($urandom_range(0, 1));
			junk.question_count = 16'($urandom_range(0, 65535));
			src_valid <= 1'b0;
			src_word <= junk;
			repeat (gap) @(posedge clk);
		end
	endtask

	// One byte of the message under construction. Only the first carries
	// msg_start and a count of one; on the others the count is noise that
	// the block must not look at.
	task automatic put_byte(input logic [7:0] b);
		if (bytes_left == 0)
			return;
		if (opens_message)
			send_byte(b, 1'b1, ONE_QUESTION);
		else
			send_byte(b, 1'b0, 16'($urandom_range(0, 65535)));
		opens_message = 1'b0;
		bytes_left--;
	endtask

	// A question with a count of one: labels of random content with lengths
	// between len_lo and len_hi, the terminator, type and class. A cut
	// stops the message after that many bytes.
	task automatic send_question(input int labels, input int len_lo, input int len_hi,
			input logic [15:0] qtype, input logic [15:0] qclass, input int cut);
		int len;
		opens_message = 1'b1;
		bytes_left = cut;
		for (int i = 0; i < labels; i++) begin
			len = $urandom_range(len_lo, len_hi);
			put_byte(8'(len));
			for (int j = 0; j < len; j++)
				put_byte(8'($urandom_range(0, 255)));
		end
		put_byte(8'h00);
		put_byte(qtype[15:8]);
		put_byte(qtype[7:0]);
		put_byte(qclass[15:8]);
		put_byte(qclass[7:0]);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Counts other than one, at both ends of the range, end the question
	// at once and report the count.
	task automatic test_rejected_counts();
		send_byte(8'hFF, 1'b1, 16'h0000);
		send_byte(8'h00, 1'b1, 16'hFFFF);
		send_byte(8'h5A, 1'b1, 16'd2);
	endtask

	// Bytes without a start while the parser is idle must give nothing.
	task automatic test_idle_bytes();
		send_byte(8'h00, 1'b0, ONE_QUESTION);
		send_byte(8'hFF, 1'b0, 16'hFFFF);
	endtask

	// The root name: a zero length byte right away gives a length of zero.
	task automatic test_root_name();
		send_question(0, 1, 1, 16'hFFFF, 16'h0000, UNCUT);
	endtask

	// Two one-byte labels, so a dot sits between them, with type and class
	// at the opposite extremes of the root test.
	task automatic test_two_labels();
		send_question(2, 1, 1, 16'h0000, 16'hFFFF, UNCUT);
	endtask

	// A new start in the middle of a label abandons the old message.
	task automatic test_restart();
		send_question(2, 3, 3, 16'h1234, 16'h0001, 3);
		send_question(1, 2, 2, 16'h0001, 16'h0001, UNCUT);
	endtask

	// Around the name limit: a single label that fits exactly, one that
	// runs one character over, and a second label whose dot is the
	// character too many, cut right after that length byte. The bytes
	// after the flag are skipped, and a new start gets the parser going
	// again.
	task automatic test_name_limit();
		send_question(1, 254, 254, 16'h00FF, 16'hFF00, UNCUT);
		send_question(1, 255, 255, 16'h0001, 16'h0001, UNCUT);
		send_question(2, 254, 254, 16'h0001, 16'h0001, 256);
		send_question(1, 5, 5, 16'h000F, 16'h0001, UNCUT);
	endtask

	// The receiver stops for a long stretch while the sender keeps words
	// coming with no gaps; the block fills up and must hold its input.
	task automatic test_backpressure();
		src_valid <= 1'b0;
		@(posedge clk);
		hold_req = 1'b1;
		wait (holding);
		steady_run = 1'b1;
		send_question(3, 4, 8, 16'h001C, 16'h0001, UNCUT);
		send_question(2, 6, 9, 16'h0005, 16'h0001, UNCUT);
		steady_run = 1'b0;
	endtask

	// Mostly well-formed questions with random content, then cut and
	// abandoned ones, rejected counts, stray bytes, and now and then a
	// long label or a name that overflows.
	task automatic test_random_traffic();
		int        k;
		int        first;
		logic [15:0] count;
		first = parsed_items;
		while (parsed_items - first < RANDOM_ITEMS) begin
			k = $urandom_range(0, 99);
			// Short bursts with neither side idling.
			steady_run = ($urandom_range(0, 9) == 0);
			if (k < 68) begin
				send_question($urandom_range(0, 4), 1, ($urandom_range(0, 9) == 0) ? 63 : 12,
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), UNCUT);
			end else if (k < 80) begin
				send_question($urandom_range(1, 4), 1, 10, 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), $urandom_range(1, 20));
			end else if (k < 88) begin
				do
					count = 16'($urandom_range(0, 65535));
				while (count == ONE_QUESTION);
				send_byte(8'($urandom_range(0, 255)), 1'b1, count);
			end else if (k < 96) begin
				// Stray words without a start; they parse on whatever
				// state the last message left behind.
				repeat ($urandom_range(1, 5))
					send_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
			end else if (k < 98) begin
				send_question(1, 128, 255, 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), UNCUT);
			end else begin
				send_question(3, 80, 120, 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), UNCUT);
			end
		end
		steady_run = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result side: a random ready pattern, mostly short stalls with a few
	// long ones, plus the one long hold-off that a test asks for. Each
	// pass drives res_ready once at a rising edge and keeps it for a run.
	// ------------------------------------------------------------------
	initial begin
		int   k;
		int   run;
		logic level;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				holding = 1'b1;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding = 1'b0;
			end else begin
				k = $urandom_range(0, 99);
				if (steady_run || k < 65) begin
					level = 1'b1;
					run = steady_run ? 1 : $urandom_range(1, 16);
				end else if (k < 93) begin
					level = 1'b0;
					run = $urandom_range(1, 3);
				end else begin
					level = 1'b0;
					run = $urandom_range(12, 60);
				end
				res_ready <= level;
				repeat (run) @(posedge clk);
			end
		end
	end

	// Every result word taken by the receiver is checked against the
	// oldest expectation. Sampling on the falling edge sees the values
	// that the next rising edge will act on.
	always @(negedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result word with nothing expected (value)",
					res_word.value, 16'h0000);
			end else begin
				oldest = pending_results.pop_front();
				if (res_word.kind != oldest.kind)
					report_mismatch("kind", 16'(res_word.kind), 16'(oldest.kind));
				if (res_word.value != oldest.value)
					report_mismatch("value", res_word.value, oldest.value);
				if (res_word.final_res != oldest.final_res)
					report_mismatch("final_res", 16'(res_word.final_res),
						16'(oldest.final_res));
			end
		end
	end

	// Watchdog: any handshake on either side counts as progress.
	always @(negedge clk) begin
		if (arst_n) begin
			if ((src_valid && src_ready) || (res_valid && res_ready))
				stalled_cycles = 0;
			else
				stalled_cycles++;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("dns_question_parser_top verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_rejected_counts();
		test_idle_bytes();
		test_root_name();
		test_two_labels();
		test_restart();
		test_name_limit();
		test_backpressure();
		test_random_traffic();

		src_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (error_count == 0)
			$display("dns_question_parser_top verification clean");
		else
			$display("dns_question_parser_top verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/dnsqp_pkg.sv
rtl/dns_question_parser_top.sv
tb/testbench.sv
